// ===== design/gcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg: shared types and constants
// Widths, mode codes, register indexes and the front/back command word.
// ----------------------------------------------------------------------------
package gcd_pkg;

    localparam int MAX_GENES = 256;
    localparam int AW        = $clog2(MAX_GENES);
    localparam int LW        = $clog2(MAX_GENES + 1);
    localparam int INN_W     = 31;
    localparam int WT_W      = 32;
    localparam int COEFF_W   = 16;
    localparam int TERM_W    = 41;
    localparam int DIS_W     = 10;
    localparam int EXC_W     = 9;
    localparam int WSUM_W    = 33 + LW;

    localparam logic [1:0] MODE_LOAD_A   = 2'd0;
    localparam logic [1:0] MODE_LOAD_B   = 2'd1;
    localparam logic [1:0] MODE_COMPUTE  = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    localparam logic [1:0] REG_DISJOINT = 2'd0;
    localparam logic [1:0] REG_EXCESS   = 2'd1;
    localparam logic [1:0] REG_WEIGHT   = 2'd2;

    // command handed from the front end to the back end
    typedef struct packed {
        logic [LW-1:0] len_a;
        logic [LW-1:0] len_b;
        logic          dropped;
    } cmd_t;

    // result word
    typedef struct packed {
        logic [TERM_W-1:0] weight_term;
        logic [TERM_W-1:0] excess_term;
        logic [TERM_W-1:0] disjoint_term;
        logic [EXC_W-1:0]  excess_cnt;
        logic [DIS_W-1:0]  disjoint_cnt;
        logic [TERM_W-1:0] distance;
        logic              overflow;
    } res_t;

endpackage

// ===== design/gcd_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_divider: restoring divider
// One quotient bit per cycle, 64-bit dividend by a narrow divisor.
// ----------------------------------------------------------------------------
module gcd_divider
    import gcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [39:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic [63:0] q_reg, q_next;
    logic [40:0] r_reg, r_next;
    logic [39:0] d_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [40:0] trial;

    // one shift-subtract step
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[39:0], q_reg[63]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
            d_reg <= divisor;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== design/gcd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_front: input word decoder and gene store writer
// Appends genes to the two lists and queues a compute command.
// ----------------------------------------------------------------------------
module gcd_front
    import gcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        mode,
    input  logic [INN_W-1:0]  inn,
    input  logic [WT_W-1:0]   wt,
    input  logic              walk_busy,
    output logic              wr_a,
    output logic              wr_b,
    output logic [AW-1:0]     wr_addr,
    output logic [INN_W-1:0]  wr_inn,
    output logic [WT_W-1:0]   wr_wt,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output cmd_t              cmd
);

    logic [LW-1:0] len_a_reg, len_b_reg;
    logic          drop_reg;
    logic          q_valid_reg;
    cmd_t          q_reg;
    logic          acc;
    logic          full_a, full_b;

    // input waits while a command is queued or the walk reads the lists
    assign in_ready = !q_valid_reg && !walk_busy;
    assign acc      = in_valid && in_ready;
    assign full_a   = len_a_reg == LW'(MAX_GENES);
    assign full_b   = len_b_reg == LW'(MAX_GENES);

    assign wr_a    = acc && mode == MODE_LOAD_A && !full_a;
    assign wr_b    = acc && mode == MODE_LOAD_B && !full_b;
    assign wr_addr = (mode == MODE_LOAD_A) ? len_a_reg[AW-1:0] : len_b_reg[AW-1:0];
    assign wr_inn  = inn;
    assign wr_wt   = wt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg   <= '0;
            len_b_reg   <= '0;
            drop_reg    <= 1'b0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_valid_reg && cmd_ready)
                q_valid_reg <= 1'b0;
            if (acc)
            begin
                case (mode)
                    MODE_LOAD_A:
                    begin
                        if (full_a) drop_reg <= 1'b1;
                        else        len_a_reg <= len_a_reg + LW'(1);
                    end
                    MODE_LOAD_B:
                    begin
                        if (full_b) drop_reg <= 1'b1;
                        else        len_b_reg <= len_b_reg + LW'(1);
                    end
                    MODE_COMPUTE:
                    begin
                        q_valid_reg <= 1'b1;
                        len_a_reg   <= '0;
                        len_b_reg   <= '0;
                        drop_reg    <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // snapshot of the lists for the walk
    always_ff @(posedge clk)
    begin
        if (acc && mode == MODE_COMPUTE)
        begin
            q_reg.len_a   <= len_a_reg;
            q_reg.len_b   <= len_b_reg;
            q_reg.dropped <= drop_reg;
        end
    end

    assign cmd_valid = q_valid_reg;
    assign cmd       = q_reg;

endmodule

// ===== design/gcd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_back: merge walk, scaling and result register
// Owns the gene memories; walks both lists one step per READ and CMP state pair.
// ----------------------------------------------------------------------------
module gcd_back
    import gcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_a,
    input  logic               wr_b,
    input  logic [AW-1:0]      wr_addr,
    input  logic [INN_W-1:0]   wr_inn,
    input  logic [WT_W-1:0]    wr_wt,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cmd_t               cmd,
    output logic               walk_busy,
    input  logic [COEFF_W-1:0] dis_coeff,
    input  logic [COEFF_W-1:0] exc_coeff,
    input  logic [COEFF_W-1:0] wt_coeff,
    output logic               out_valid,
    input  logic               out_ready,
    output res_t               res
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_CMP   = 4'd2;
    localparam logic [3:0] S_MUL1  = 4'd3;
    localparam logic [3:0] S_DIVD  = 4'd4;
    localparam logic [3:0] S_WAITD = 4'd5;
    localparam logic [3:0] S_DIVE  = 4'd6;
    localparam logic [3:0] S_WAITE = 4'd7;
    localparam logic [3:0] S_DIVW  = 4'd8;
    localparam logic [3:0] S_WAITW = 4'd9;
    localparam logic [3:0] S_SUM   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    // gene memories
    logic [INN_W-1:0] mem_ia [MAX_GENES];
    logic [WT_W-1:0]  mem_wa [MAX_GENES];
    logic [INN_W-1:0] mem_ib [MAX_GENES];
    logic [WT_W-1:0]  mem_wb [MAX_GENES];
    logic [INN_W-1:0] ia_reg, ib_reg;
    logic [WT_W-1:0]  wa_reg, wb_reg;

    logic [3:0]        state_reg;
    cmd_t              c_reg;
    logic [LW-1:0]     a_reg, b_reg, maxl_reg;
    logic [DIS_W-1:0]  dis_reg;
    logic [EXC_W-1:0]  exc_reg;
    logic [WSUM_W-1:0] wsum_reg;
    logic [63:0]       pd_reg, pe_reg, pw_reg;
    logic [TERM_W-1:0] dt_reg, et_reg, wtm_reg;
    logic              empty_reg;
    logic              ov_valid_reg;
    res_t              res_reg;

    logic        div_start, div_done;
    logic [63:0] div_dvd, div_q;
    logic [39:0] div_dvs;
    logic signed [WT_W:0] diff;
    logic [WT_W:0]        adiff;
    logic [TERM_W+1:0]    total;
    logic [TERM_W-1:0]    sat_q;

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_ia[wr_addr] <= wr_inn;
            mem_wa[wr_addr] <= wr_wt;
        end
        if (wr_b)
        begin
            mem_ib[wr_addr] <= wr_inn;
            mem_wb[wr_addr] <= wr_wt;
        end
        ia_reg <= mem_ia[a_reg[AW-1:0]];
        wa_reg <= mem_wa[a_reg[AW-1:0]];
        ib_reg <= mem_ib[b_reg[AW-1:0]];
        wb_reg <= mem_wb[b_reg[AW-1:0]];
    end

    assign diff  = $signed({wa_reg[WT_W-1], wa_reg}) - $signed({wb_reg[WT_W-1], wb_reg});
    assign adiff = diff[WT_W] ? -diff : diff;
    assign sat_q = (|div_q[63:TERM_W]) ? {TERM_W{1'b1}} : div_q[TERM_W-1:0];
    assign total = {2'b0, dt_reg} + {2'b0, et_reg} + {2'b0, wtm_reg};

    assign div_start = state_reg == S_DIVD || state_reg == S_DIVE || state_reg == S_DIVW;
    assign div_dvd   = (state_reg == S_DIVD) ? pd_reg :
                       (state_reg == S_DIVE) ? pe_reg : pw_reg;
    assign div_dvs   = (state_reg == S_DIVW) ? 40'({maxl_reg, 8'd0}) : 40'(maxl_reg);

    gcd_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    assign cmd_ready = state_reg == S_IDLE;
    // the walk reads the gene memories, so loads must hold off
    assign walk_busy = state_reg == S_READ || state_reg == S_CMP;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ov_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_OUT && (!ov_valid_reg || out_ready))
                ov_valid_reg <= 1'b1;
            else if (out_ready)
                ov_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:  if (cmd_valid) state_reg <= S_READ;
                S_READ:
                begin
                    if (empty_reg)
                        state_reg <= S_SUM;
                    else if (a_reg < c_reg.len_a && b_reg < c_reg.len_b)
                        state_reg <= S_CMP;
                    else
                        state_reg <= S_MUL1;
                end
                S_CMP:   state_reg <= S_READ;
                S_MUL1:  state_reg <= S_DIVD;
                S_DIVD:  state_reg <= S_WAITD;
                S_WAITD: if (div_done) state_reg <= S_DIVE;
                S_DIVE:  state_reg <= S_WAITE;
                S_WAITE: if (div_done) state_reg <= S_DIVW;
                S_DIVW:  state_reg <= S_WAITW;
                S_WAITW: if (div_done) state_reg <= S_SUM;
                S_SUM:   state_reg <= S_OUT;
                S_OUT:   if (!ov_valid_reg || out_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                c_reg     <= cmd;
                a_reg     <= '0;
                b_reg     <= '0;
                dis_reg   <= '0;
                wsum_reg  <= '0;
                maxl_reg  <= (cmd.len_a > cmd.len_b) ? cmd.len_a : cmd.len_b;
                empty_reg <= cmd.len_a == '0 || cmd.len_b == '0;
                dt_reg    <= '0;
                wtm_reg   <= '0;
                exc_reg   <= EXC_W'((cmd.len_a > cmd.len_b) ? cmd.len_a - cmd.len_b
                                                             : cmd.len_b - cmd.len_a);
                et_reg    <= (cmd.len_a != cmd.len_b) ? TERM_W'({exc_coeff, 8'd0}) : '0;
            end
            S_CMP:
            begin
                if (ia_reg < ib_reg)
                begin
                    dis_reg <= dis_reg + DIS_W'(1);
                    a_reg   <= a_reg + LW'(1);
                end
                else if (ib_reg < ia_reg)
                begin
                    dis_reg <= dis_reg + DIS_W'(1);
                    b_reg   <= b_reg + LW'(1);
                end
                else
                begin
                    wsum_reg <= wsum_reg + WSUM_W'(adiff);
                    a_reg    <= a_reg + LW'(1);
                    b_reg    <= b_reg + LW'(1);
                end
            end
            S_MUL1:
            begin
                if (a_reg < c_reg.len_a)
                    exc_reg <= EXC_W'(c_reg.len_a - a_reg);
                else
                    exc_reg <= EXC_W'(c_reg.len_b - b_reg);
                pd_reg <= {30'd0, 26'(dis_coeff) * 26'(dis_reg), 8'd0};
                pw_reg <= 64'(wt_coeff) * 64'(wsum_reg);
            end
            S_DIVD:  pe_reg <= {31'd0, 25'(exc_coeff) * 25'(exc_reg), 8'd0};
            S_WAITD: if (div_done) dt_reg <= sat_q;
            S_WAITE: if (div_done) et_reg <= sat_q;
            S_WAITW: if (div_done) wtm_reg <= sat_q;
            // load the result register only once the previous word has left
            S_OUT:
            begin
                if (!ov_valid_reg || out_ready)
                begin
                    res_reg.distance      <= total[TERM_W+1:TERM_W] != 2'b0 ? {TERM_W{1'b1}}
                                                                            : total[TERM_W-1:0];
                    res_reg.disjoint_cnt  <= dis_reg;
                    res_reg.excess_cnt    <= exc_reg;
                    res_reg.disjoint_term <= dt_reg;
                    res_reg.excess_term   <= et_reg;
                    res_reg.weight_term   <= wtm_reg;
                    res_reg.overflow      <= c_reg.dropped;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = ov_valid_reg;
    assign res       = res_reg;

endmodule

// ===== design/genome_compatibility_distance_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// genome_compatibility_distance_unit: gene list compatibility distance
// Loads two gene lists and computes disjoint/excess/weight distance terms.
// ----------------------------------------------------------------------------
// channel   dir  payload
// s_axis    in   mode, gene_innovation, gene_weight (tdata)
// m_axis    out  distance..overflow (tdata)
// cfg       in   coefficient writes, index 0..2
//
// A compute runs the merge walk, then three divisions on the shared
// one-bit-per-cycle divider.
// A one-entry command queue lets the next pair load while the back end divides;
// s_axis stalls while a command is queued and while the walk reads the lists.
// Reset clears lengths and flags and sets the coefficients to 256; gene memories are not cleared.
// m_axis stalls hold the result register; the back end waits on it.
// ----------------------------------------------------------------------------
module genome_compatibility_distance_unit
    import gcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[1:0], gene_innovation[32:2], gene_weight[64:33], zero pad
    input  logic [71:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // distance[40:0], disjoint_cnt[50:41], excess_cnt[59:51],
    // disjoint_term[100:60], excess_term[141:101], weight_term[182:142],
    // overflow[183], zero pad
    output logic [191:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    logic [COEFF_W-1:0] dis_c_reg, exc_c_reg, wt_c_reg;
    logic               wr_a, wr_b, cmd_valid, cmd_ready, walk_busy;
    logic [AW-1:0]      wr_addr;
    logic [INN_W-1:0]   wr_inn;
    logic [WT_W-1:0]    wr_wt;
    cmd_t               cmd;
    res_t               res;

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dis_c_reg <= 16'd256;
            exc_c_reg <= 16'd256;
            wt_c_reg  <= 16'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DISJOINT: dis_c_reg <= cfg_data;
                REG_EXCESS:   exc_c_reg <= cfg_data;
                REG_WEIGHT:   wt_c_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    gcd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .mode      (s_axis_tdata[1:0]),
        .inn       (s_axis_tdata[32:2]),
        .wt        (s_axis_tdata[64:33]),
        .walk_busy (walk_busy),
        .wr_a      (wr_a),
        .wr_b      (wr_b),
        .wr_addr   (wr_addr),
        .wr_inn    (wr_inn),
        .wr_wt     (wr_wt),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    gcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_a      (wr_a),
        .wr_b      (wr_b),
        .wr_addr   (wr_addr),
        .wr_inn    (wr_inn),
        .wr_wt     (wr_wt),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .walk_busy (walk_busy),
        .dis_coeff (dis_c_reg),
        .exc_coeff (exc_c_reg),
        .wt_coeff  (wt_c_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {8'd0, res.overflow, res.weight_term, res.excess_term,
                           res.disjoint_term, res.excess_cnt, res.disjoint_cnt,
                           res.distance};

endmodule

// ===== design/gcd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_port_checks: port-level checks
// Watches the result stream port of the top level.
// ----------------------------------------------------------------------------
module gcd_port_checks
    import gcd_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [191:0] m_axis_tdata
);

    // stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // distance never below the disjoint or the excess term
    a_dist: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[40:0] >= m_axis_tdata[100:60]
                       && m_axis_tdata[40:0] >= m_axis_tdata[141:101])
        else $error("distance below a term");

    // pad bits are zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[191:184] == 8'd0)
        else $error("pad bits set");

endmodule

bind genome_compatibility_distance_unit gcd_port_checks u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== test/gcd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_checker: result predictor and scoreboard
// Watches the gene input and result streams and the coefficient port, keeps
// its own copy of both gene lists, and checks every result word field by field.
// ----------------------------------------------------------------------------
module gcd_checker
    import gcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [191:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    output int           errors,
    output int           pending,
    output int           results_seen
);

    typedef struct packed {
        logic [40:0] distance;
        logic [9:0]  dis_cnt;
        logic [8:0]  exc_cnt;
        logic [40:0] dterm;
        logic [40:0] eterm;
        logic [40:0] wterm;
        logic        ovf;
    } dist_t;

    localparam logic [63:0] TERM_MAX = (64'd1 << 41) - 1;

    logic [30:0] inn_a [MAX_GENES];
    logic [31:0] wt_a  [MAX_GENES];
    logic [30:0] inn_b [MAX_GENES];
    logic [31:0] wt_b  [MAX_GENES];
    int          len_a, len_b;
    logic        dropped;
    logic [63:0] c_dis, c_exc, c_wt;
    dist_t       expected_q [$];

    function automatic logic [63:0] clip41(logic [63:0] v);
        return (v > TERM_MAX) ? TERM_MAX : v;
    endfunction

    // merge walk of the two lists and the scaled terms
    function automatic dist_t walk_lists();
        dist_t       r;
        int          i, j, longest;
        logic [63:0] dis, exc, wsum, diff;
        dis = 0; exc = 0; wsum = 0; i = 0; j = 0;
        r.dterm = 0; r.eterm = 0; r.wterm = 0;
        if (len_a == 0 || len_b == 0) begin
            exc = (len_a > len_b) ? len_a - len_b : len_b - len_a;
            if (exc != 0)
                r.eterm = 41'(clip41(c_exc << 8));
        end
        else begin
            longest = (len_a > len_b) ? len_a : len_b;
            while (i < len_a && j < len_b) begin
                if (inn_a[i] < inn_b[j]) begin
                    dis++;
                    i++;
                end
                else if (inn_b[j] < inn_a[i]) begin
                    dis++;
                    j++;
                end
                else begin
                    diff = 64'($signed(wt_a[i])) - 64'($signed(wt_b[j]));
                    if (diff[63])
                        diff = -diff;
                    wsum += diff;
                    i++;
                    j++;
                end
            end
            exc = (i < len_a) ? len_a - i : len_b - j;
            r.dterm = 41'(clip41((c_dis * dis * 256) / longest));
            r.eterm = 41'(clip41((c_exc * exc * 256) / longest));
            r.wterm = 41'(clip41((c_wt * wsum) / (64'(longest) * 256)));
        end
        r.distance = 41'(clip41(64'(r.dterm) + r.eterm + r.wterm));
        r.dis_cnt  = dis[9:0];
        r.exc_cnt  = exc[8:0];
        r.ovf      = dropped;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        dist_t       got, exp_r;
        logic [1:0]  mode;
        if (!rst_n) begin
            len_a = 0; len_b = 0; dropped = 0;
            c_dis = 256; c_exc = 256; c_wt = 256;
            expected_q.delete();
            errors <= 0;
            pending <= 0;
            results_seen <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_DISJOINT: c_dis = 64'(cfg_data);
                    REG_EXCESS:   c_exc = 64'(cfg_data);
                    REG_WEIGHT:   c_wt  = 64'(cfg_data);
                    default: ;
                endcase
            end
            // result side
            if (m_axis_tvalid && m_axis_tready) begin
                got.distance = m_axis_tdata[40:0];
                got.dis_cnt  = m_axis_tdata[50:41];
                got.exc_cnt  = m_axis_tdata[59:51];
                got.dterm    = m_axis_tdata[100:60];
                got.eterm    = m_axis_tdata[141:101];
                got.wterm    = m_axis_tdata[182:142];
                got.ovf      = m_axis_tdata[183];
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, m_axis_tdata);
                    errors <= errors + 1;
                end
                else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: mismatch exp dist=%h dc=%0d ec=%0d dt=%h et=%h wt=%h ov=%b",
                                 $time, exp_r.distance, exp_r.dis_cnt, exp_r.exc_cnt,
                                 exp_r.dterm, exp_r.eterm, exp_r.wterm, exp_r.ovf);
                        $display("%0t:          got dist=%h dc=%0d ec=%0d dt=%h et=%h wt=%h ov=%b",
                                 $time, got.distance, got.dis_cnt, got.exc_cnt,
                                 got.dterm, got.eterm, got.wterm, got.ovf);
                        errors <= errors + 1;
                    end
                end
            end
            // gene side
            if (s_axis_tvalid && s_axis_tready) begin
                mode = s_axis_tdata[1:0];
                if (mode == MODE_LOAD_A) begin
                    if (len_a >= MAX_GENES)
                        dropped = 1;
                    else begin
                        inn_a[len_a] = s_axis_tdata[32:2];
                        wt_a[len_a]  = s_axis_tdata[64:33];
                        len_a++;
                    end
                end
                else if (mode == MODE_LOAD_B) begin
                    if (len_b >= MAX_GENES)
                        dropped = 1;
                    else begin
                        inn_b[len_b] = s_axis_tdata[32:2];
                        wt_b[len_b]  = s_axis_tdata[64:33];
                        len_b++;
                    end
                end
                else if (mode == MODE_COMPUTE) begin
                    expected_q.push_back(walk_lists());
                    len_a = 0; len_b = 0; dropped = 0;
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: compatibility distance unit testbench
// Loads gene list pairs (sorted, unsorted, empty, overfull) with directed and
// random content under varying stream gaps and stalls and coefficient settings.
// ----------------------------------------------------------------------------
module tb_top;
    import gcd_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [191:0] m_axis_tdata;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_data;
    int           errors, pending, results_seen;
    int           send_idle_pct, recv_stall_pct;
    int           genes_sent;
    int           hold_cycles = 0;
    logic         hold_armed = 1'b0;
    logic         hold_done = 1'b0;

    genome_compatibility_distance_unit uut (.*);

    gcd_checker chk (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    // result side backpressure, with one long hold-off once armed
    always @(negedge clk)
    begin
        if (hold_armed && !hold_done)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= hold_cycles + 1;
            if (hold_cycles == 2999)
                hold_done <= 1'b1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one word on the gene stream, with random leading gaps
    task automatic send_word(logic [1:0] mode, logic [30:0] inn, logic [31:0] wt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, wt, inn, mode};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        genes_sent++;
    endtask

    task automatic write_coeff(logic [1:0] idx, logic [15:0] val);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (1200) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_coeffs(logic [15:0] d, logic [15:0] e, logic [15:0] w);
        write_coeff(REG_DISJOINT, d);
        write_coeff(REG_EXCESS, e);
        write_coeff(REG_WEIGHT, w);
    endtask

    // a pair of lists: sorted ascending unless told otherwise, shared genes likely
    task automatic send_pair(int na, int nb, bit sorted_lists, bit wide_vals);
        logic [30:0] ia, ib;
        logic [31:0] w;
        ia = wide_vals ? 31'($urandom) >> 2 : 31'($urandom_range(20));
        ib = $urandom_range(1) ? ia : ia + 31'($urandom_range(3));
        for (int k = 0; k < na; k++)
        begin
            w = wide_vals ? $urandom : 32'($signed($urandom_range(4000)) - 2000);
            send_word(MODE_LOAD_A, sorted_lists ? ia : 31'($urandom), w);
            ia = ia + 31'($urandom_range(3));
        end
        for (int k = 0; k < nb; k++)
        begin
            w = wide_vals ? $urandom : 32'($signed($urandom_range(4000)) - 2000);
            send_word(MODE_LOAD_B, sorted_lists ? ib : 31'($urandom), w);
            ib = ib + 31'($urandom_range(3));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = REG_DISJOINT;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        genes_sent = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty pairs, extremes, ignored mode, unsorted
        send_word(MODE_COMPUTE, '0, '0);
        send_word(MODE_LOAD_A, 31'h7fffffff, 32'h7fffffff);
        send_word(MODE_COMPUTE, '0, '0);
        send_word(MODE_LOAD_B, 31'd0, 32'h80000000);
        send_word(MODE_LOAD_B, 31'd1, 32'hffffffff);
        send_word(MODE_COMPUTE, 31'h7fffffff, 32'hffffffff);
        send_word(MODE_LOAD_A, 31'd5, 32'h80000000);
        send_word(MODE_RESERVED, 31'h7fffffff, 32'hffffffff);
        send_word(MODE_LOAD_B, 31'd5, 32'h7fffffff);
        send_word(MODE_LOAD_A, 31'd9, 32'h0);
        send_word(MODE_LOAD_B, 31'd2, 32'h0);
        send_word(MODE_COMPUTE, '0, '0);
        send_pair(4, 3, 0, 1);
        send_word(MODE_COMPUTE, '0, '0);

        // saturation with maximum coefficients and an overfull first list, then an overfull second list
        set_coeffs(16'hffff, 16'hffff, 16'hffff);
        send_pair(260, 1, 1, 1);
        send_word(MODE_COMPUTE, '0, '0);
        send_pair(3, 5, 1, 1);
        send_word(MODE_COMPUTE, '0, '0);
        set_coeffs(16'h0000, 16'h0000, 16'h0000);
        send_pair(2, 258, 1, 0);
        send_word(MODE_COMPUTE, '0, '0);

        // random phases with assorted idling and coefficients
        for (int ph = 0; ph < 8; ph++)
        begin
            set_coeffs(16'($urandom), 16'($urandom), 16'($urandom));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            if (ph == 2)
                hold_armed = 1'b1;
            for (int p = 0; p < 7; p++)
            begin
                if ($urandom_range(9) == 0)
                    send_word(2'($urandom_range(3)), 31'($urandom), $urandom);
                send_pair($urandom_range(12), $urandom_range(12),
                          $urandom_range(9) != 0, $urandom_range(3) == 0);
                send_word(MODE_COMPUTE, 31'($urandom), $urandom);
            end
        end

        recv_stall_pct = 0;
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (1200) @(negedge clk);
        $display("Covered %0d gene stream words and %0d distance results,",
                 genes_sent, results_seen);
        $display("across empty, unsorted, overfull and saturating cases.");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
